@@ sv/usesc_pkg.sv @@
// ----------------------------------------------------------------------------
// usesc_pkg: shared types and constants of the unicode string escaper
// Item descriptor passed from the classifier to the byte sequencer, the
// character constants and the hex digit encoder.
// ----------------------------------------------------------------------------
package usesc_pkg;

  localparam int unsigned CpW        = 31;
  localparam int unsigned ByteW      = 7;
  localparam int unsigned StepW      = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteW-1:0] ChQuote   = 7'h22;
  localparam logic [ByteW-1:0] ChBslash  = 7'h5C;
  localparam logic [ByteW-1:0] ChLowerU  = 7'h75;
  localparam logic [ByteW-1:0] ChUpperU  = 7'h55;
  localparam logic [CpW-1:0]   CpPrintLo = 31'h20;
  localparam logic [CpW-1:0]   CpPrintHi = 31'h7E;
  localparam logic [CpW-1:0]   CpQuote   = 31'h22;
  localparam logic [CpW-1:0]   CpBslash  = 31'h5C;
  localparam logic [CpW-1:0]   CpBmpEnd  = 31'h10000;

  typedef enum logic [2:0] {
    KIND_END,
    KIND_ESC,
    KIND_PLAIN,
    KIND_U4,
    KIND_U8
  } kind_t;

  typedef struct packed {
    logic            open_q;
    kind_t           kind;
    logic [CpW-1:0]  cp;
  } desc_t;

  localparam int unsigned DescW = $bits(desc_t);

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] d);
    logic [ByteW-1:0] c;
    if (d < 4'hA) begin
      c = 7'h30 + {3'b000, d};
    end else begin
      c = 7'h37 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

@@ sv/usesc_front.sv @@
// ----------------------------------------------------------------------------
// usesc_front: item classifier
// Accepts input items, tracks whether a string is open and turns each item
// into a descriptor for the queue.
// ----------------------------------------------------------------------------
module usesc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [30:0] code_point
  input  logic                      in_tuser,   // [0] req_type
  input  logic                      q_full,
  output logic                      q_push,
  output usesc_pkg::desc_t          q_desc
);
  import usesc_pkg::*;

  logic           inside_r;
  logic           inside_nxt;
  logic [CpW-1:0] cp;
  kind_t          kind;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign cp        = in_tdata[CpW-1:0];

  always_comb begin
    if (in_tuser) begin
      kind = KIND_END;
    end else if (cp == CpQuote || cp == CpBslash) begin
      kind = KIND_ESC;
    end else if (cp >= CpPrintLo && cp <= CpPrintHi) begin
      kind = KIND_PLAIN;
    end else if (cp < CpBmpEnd) begin
      kind = KIND_U4;
    end else begin
      kind = KIND_U8;
    end
  end

  assign q_desc = '{open_q: !inside_r, kind: kind, cp: cp};

  always_comb begin
    inside_nxt = inside_r;
    if (q_push) begin
      inside_nxt = !in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

@@ sv/usesc_fifo.sv @@
// ----------------------------------------------------------------------------
// usesc_fifo: descriptor queue
// Small register queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module usesc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             vld,
  output logic [Width-1:0] dout
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign full = (cnt_r == CntFull);
  assign vld  = (cnt_r != '0);
  assign dout = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> vld)
    else $error("queue read while empty");

endmodule

@@ sv/usesc_back.sv @@
// ----------------------------------------------------------------------------
// usesc_back: byte sequencer
// Walks one descriptor a byte per cycle while out_tready does not stall it.
// ----------------------------------------------------------------------------
module usesc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_vld,
  input  usesc_pkg::desc_t     q_desc,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [6:0] out_byte
  output logic                 out_tlast   // last_of_run
);
  import usesc_pkg::*;

  desc_t            cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             ovld_r, ovld_nxt;
  logic [ByteW-1:0] obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;

  logic [StepW-1:0] body_len;
  logic [StepW-1:0] len;
  logic [StepW-1:0] pos;
  logic [StepW-1:0] digits;
  logic [StepW-1:0] nib_sel;
  logic [31:0]      cp32;
  logic [3:0]       nib;
  logic [ByteW-1:0] byte_c;
  logic             last_c;
  logic             slot;
  logic             emit;

  always_comb begin
    case (cur_r.kind)
      KIND_END:   body_len = 4'd1;
      KIND_ESC:   body_len = 4'd2;
      KIND_PLAIN: body_len = 4'd1;
      KIND_U4:    body_len = 4'd6;
      KIND_U8:    body_len = 4'd10;
      default:    body_len = 4'd1;
    endcase
  end

  assign len     = body_len + {3'b000, cur_r.open_q};
  assign last_c  = (step_r == len - 1'b1);
  assign pos     = step_r - {3'b000, cur_r.open_q};
  assign digits  = (cur_r.kind == KIND_U8) ? 4'd8 : 4'd4;
  assign nib_sel = digits + 4'd1 - pos;
  assign cp32    = {1'b0, cur_r.cp};
  assign nib     = cp32[nib_sel[2:0]*4 +: 4];

  always_comb begin
    if (cur_r.open_q && step_r == '0) begin
      byte_c = ChQuote;
    end else begin
      case (cur_r.kind)
        KIND_END:   byte_c = ChQuote;
        KIND_ESC:   byte_c = (pos == '0) ? ChBslash : cur_r.cp[ByteW-1:0];
        KIND_PLAIN: byte_c = cur_r.cp[ByteW-1:0];
        KIND_U4, KIND_U8: begin
          if (pos == 4'd0) begin
            byte_c = ChBslash;
          end else if (pos == 4'd1) begin
            byte_c = (cur_r.kind == KIND_U8) ? ChUpperU : ChLowerU;
          end else begin
            byte_c = hex_char(nib);
          end
        end
        default:    byte_c = ChQuote;
      endcase
    end
  end

  assign slot  = !ovld_r || out_tready;
  assign emit  = cur_vld_r && slot;
  assign q_pop = q_vld && (!cur_vld_r || (emit && last_c));

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    step_nxt    = step_r;
    if (q_pop) begin
      cur_nxt     = q_desc;
      cur_vld_nxt = 1'b1;
      step_nxt    = '0;
    end else if (emit) begin
      step_nxt = step_r + 1'b1;
      if (last_c) begin
        cur_vld_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    ovld_nxt  = ovld_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (slot) begin
      ovld_nxt  = cur_vld_r;
      obyte_nxt = byte_c;
      olast_nxt = last_c;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      step_r    <= '0;
      ovld_r    <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      step_r    <= step_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {1'b0, obyte_r};
  assign out_tlast  = olast_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (step_r < len))
    else $error("sequencer step past end of item");

  a_pop_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && cur_vld_r) |-> (emit && last_c))
    else $error("descriptor replaced before its last byte");

endmodule

@@ sv/unicode_string_escaper.sv @@
// ----------------------------------------------------------------------------
// unicode_string_escaper: quoted, escaped ASCII string from code points
// First byte of an item passes the queue, item register and output register.
// Throughput: one output byte per cycle while out_tready is not held low; an
// item is 1 to 11 bytes, set by the byte sequencer; the classifier takes an
// item per cycle while the descriptor queue has room.
// Reset: synchronous, active low; marks no string open, empties the queue.
// ----------------------------------------------------------------------------
module unicode_string_escaper #(
  parameter int unsigned QUEUE_DEPTH = usesc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] code_point
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] out_byte
  output logic        out_tlast   // last_of_run
);
  import usesc_pkg::*;

  desc_t push_desc;
  desc_t pop_desc;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_vld;

  usesc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  usesc_fifo #(
    .Width (DescW),
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .vld   (q_vld),
    .dout  (pop_desc)
  );

  usesc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_desc     (pop_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
